[rtl/core/tkas_pkg.sv]
// ----------------------------------------------------------------------------
// tkas_pkg: shared types for the top-k activity selector
// Word layouts of the candidate, result and configuration channels, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tkas_pkg;

	localparam int ID_W    = 32;
	localparam int SCORE_W = 32;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DRAIN  = 1'b1;

	typedef logic [CAP_W-1:0] cap_t;

	typedef struct packed {
		logic               operation;
		logic [ID_W-1:0]    clause_id;
		logic [SCORE_W-1:0] activity;
	} cand_t;

	typedef struct packed {
		logic               entry_valid;
		logic [ID_W-1:0]    entry_id;
		logic [SCORE_W-1:0] entry_activity;
		logic               last;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic insert;   // candidate word accepted, insert it
		logic pop;      // move head entry into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;   // output register can take a word this cycle
		logic drain_end;  // the next pop is the final word of the drain
	} status_t;

endpackage

[rtl/core/tkas_stream_if.sv]
// ----------------------------------------------------------------------------
// tkas_stream_if: valid/ready channel
// One word moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface tkas_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/top_k_activity_selector.sv]
// ----------------------------------------------------------------------------
// top_k_activity_selector: keeps the MAX_KEPT most active identifiers
// Sorted insert list with duplicate drop and drain-and-clear.
// ----------------------------------------------------------------------------
// An insert word (operation 0) is taken at its handshake: every held cell
// compares its activity and identifier with the candidate in parallel, and
// the candidate lands ahead of the first entry with strictly lower activity
// while the tail shifts down; a duplicate identifier leaves the list
// untouched and a candidate past the capacity is dropped. Inserts produce
// no result words and the input stays ready for one word per cycle. A drain
// word (operation 1) holds the input off while the held entries are popped
// from the head cell into the output register, best first, the final one
// with last set; a pop waits while the output register is still full and
// result.ready is low. An empty list gives a single word with entry_valid 0
// and last 1. Drain speed is one word per cycle while result.ready stays
// high, set by the single output register. capacity_limit is written over
// cfg; the user must write it only while the block is idle, which the block
// itself does not enforce; 0 acts as 1, values above MAX_KEPT as MAX_KEPT,
// and lowering it drops the tail entries at once. The entry store is a row
// of flip-flop cells with no reset; only cells below the fill count are read.
// ----------------------------------------------------------------------------
module top_k_activity_selector #(
	parameter int MAX_KEPT = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	tkas_stream_if.sink   cand,
	tkas_stream_if.sink   cfg,
	tkas_stream_if.source result
);
	import tkas_pkg::*;

	cmd_t    cmd;
	status_t status;
	cand_t   cand_word;

	assign cand_word = cand.data;

	// controller: decides when words are taken and when the list pops
	tkas_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_valid (cand.valid),
		.cand_op    (cand_word.operation),
		.cand_ready (cand.ready),
		.cmd        (cmd),
		.status     (status)
	);

	// datapath: cells, capacity register, output word register
	tkas_datapath #(
		.MAX_KEPT (MAX_KEPT)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cand   (cand_word),
		.cmd    (cmd),
		.status (status),
		.cfg    (cfg),
		.result (result)
	);

endmodule

[rtl/core/tkas_ctrl.sv]
// ----------------------------------------------------------------------------
// tkas_ctrl: sequencing controller
// Idle accepts candidate words; a drain word holds the input off while
// the kept list is popped into the output register one word at a time.
// ----------------------------------------------------------------------------
module tkas_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cand_valid,
	input  logic              cand_op,
	output logic              cand_ready,
	output tkas_pkg::cmd_t    cmd,
	input  tkas_pkg::status_t status
);
	import tkas_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic state_q;
	logic accept;

	assign cand_ready = (state_q == ST_IDLE);
	assign accept     = cand_valid && cand_ready;

	always_comb begin
		cmd.insert = accept && (cand_op == OP_INSERT);
		cmd.pop    = (state_q == ST_DRAIN) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && cand_op == OP_DRAIN) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (cmd.pop && status.drain_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// inserts must never land while the list is being popped
	a_no_insert_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> !cmd.insert)
		else $error("insert issued during drain");

endmodule

[rtl/core/tkas_datapath.sv]
// ----------------------------------------------------------------------------
// tkas_datapath: sorted entry cells, capacity register, output register
// All cells compare against the candidate at once; the insert point and
// the shift-down happen together at the same edge. Pops shift the cells up by one.
// ----------------------------------------------------------------------------
module tkas_datapath #(
	parameter int MAX_KEPT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tkas_pkg::cand_t    cand,
	input  tkas_pkg::cmd_t     cmd,
	output tkas_pkg::status_t  status,
	tkas_stream_if.sink        cfg,
	tkas_stream_if.source      result
);
	import tkas_pkg::*;

	localparam int CNT_W = $clog2(MAX_KEPT + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [ID_W-1:0]    id_q    [MAX_KEPT];
	logic [SCORE_W-1:0] score_q [MAX_KEPT];
	logic [ID_W-1:0]    prev_id    [MAX_KEPT];
	logic [SCORE_W-1:0] prev_score [MAX_KEPT];
	logic [ID_W-1:0]    next_id    [MAX_KEPT];
	logic [SCORE_W-1:0] next_score [MAX_KEPT];

	logic [MAX_KEPT-1:0] valid_c, flag_c, take_prev_c, in_cap_c, dup_c;
	logic [CNT_W-1:0]    fill_q, cap_eff, cap_new_eff, fill_clamped;
	cap_t                cap_q;
	logic                ins_ok;
	logic                out_valid_q;
	result_t             out_q;
	logic                wr_cap;

	// capacity of zero acts as one, above MAX_KEPT acts as MAX_KEPT
	function automatic logic [CNT_W-1:0] clamp_cap(input cap_t c);
		logic [CMP_W-1:0] cw;
		cw = CMP_W'(c);
		if (c == '0) begin
			return CNT_W'(1);
		end else if (cw > CMP_W'(MAX_KEPT)) begin
			return CNT_W'(MAX_KEPT);
		end else begin
			return CNT_W'(cw);
		end
	endfunction

	assign cap_eff      = clamp_cap(cap_q);
	assign cap_new_eff  = clamp_cap(cfg.data);
	assign fill_clamped = (fill_q > cap_new_eff) ? cap_new_eff : fill_q;
	assign wr_cap       = cfg.valid && cfg.ready;
	assign cfg.ready    = 1'b1;

	always_comb begin
		prev_id[0]    = cand.clause_id;
		prev_score[0] = cand.activity;
		for (int j = 1; j < MAX_KEPT; j++) begin
			prev_id[j]    = id_q[j-1];
			prev_score[j] = score_q[j-1];
		end
		for (int j = 0; j < MAX_KEPT - 1; j++) begin
			next_id[j]    = id_q[j+1];
			next_score[j] = score_q[j+1];
		end
		next_id[MAX_KEPT-1]    = id_q[MAX_KEPT-1];
		next_score[MAX_KEPT-1] = score_q[MAX_KEPT-1];
	end

	// flag is monotone over the sorted list: set from the insert point on
	always_comb begin
		for (int j = 0; j < MAX_KEPT; j++) begin
			valid_c[j]  = CNT_W'(j) < fill_q;
			in_cap_c[j] = CNT_W'(j) < cap_eff;
			dup_c[j]    = valid_c[j] && (id_q[j] == cand.clause_id);
			flag_c[j]   = !valid_c[j] || (score_q[j] < cand.activity);
		end
		// cells behind the insert point take their upper neighbor
		take_prev_c[0] = 1'b0;
		for (int j = 1; j < MAX_KEPT; j++) begin
			take_prev_c[j] = flag_c[j-1];
		end
	end

	assign ins_ok = cmd.insert && !(|dup_c) && (|(flag_c & in_cap_c));

	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_KEPT; j++) begin
			if (ins_ok) begin
				if (flag_c[j]) begin
					if (take_prev_c[j]) begin
						id_q[j]    <= prev_id[j];
						score_q[j] <= prev_score[j];
					end else begin
						// insert point
						id_q[j]    <= cand.clause_id;
						score_q[j] <= cand.activity;
					end
				end
			end else if (cmd.pop) begin
				id_q[j]    <= next_id[j];
				score_q[j] <= next_score[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			fill_q <= '0;
		end else begin
			if (wr_cap) begin
				cap_q <= cfg.data;
			end
			priority if (wr_cap) begin
				fill_q <= fill_clamped;
			end else if (ins_ok) begin
				if (fill_q < cap_eff) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end else if (cmd.pop) begin
				if (fill_q != '0) begin
					fill_q <= fill_q - CNT_W'(1);
				end
			end else begin
				fill_q <= fill_q;
			end
		end
	end

	// output register
	assign status.out_free  = !out_valid_q || result.ready;
	assign status.drain_end = (fill_q <= CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pop) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_q.entry_valid    <= (fill_q != '0);
			out_q.entry_id       <= (fill_q != '0) ? id_q[0] : '0;
			out_q.entry_activity <= (fill_q != '0) ? score_q[0] : '0;
			out_q.last           <= (fill_q <= CNT_W'(1));
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	a_fill_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_eff)
		else $error("fill count above capacity");

	a_empty_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop && fill_q == '0) |=>
			(out_valid_q && out_q.last && !out_q.entry_valid))
		else $error("empty drain word malformed");

	a_first_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.insert && !cmd.pop && !wr_cap && fill_q == '0) |=> (fill_q == CNT_W'(1)))
		else $error("insert into empty list lost");

endmodule

[dv/top_k_activity_selector_tb.sv]
// ----------------------------------------------------------------------------
// top_k_activity_selector_tb: self-checking bench for the top-k selector
// Directed and random candidate streams across several capacity settings.
// Inserts and drains are predicted at the cand handshake, and every drained
// word is checked field by field against the predicted list. Both channels
// stall at random.
// ----------------------------------------------------------------------------
module top_k_activity_selector_tb;

	import tkas_pkg::*;

	localparam int MAX_KEPT     = 16;
	localparam int SETTLE       = 4;       // idle cycles before a cfg write
	localparam int LONG_HOLD    = 120;     // forced result stall, in cycles
	localparam int TAIL_CYCLES  = 20;
	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_ITEMS = 190;     // total cand words, directed included

	typedef enum logic [1:0] {
		ACT_WORD,   // offer one cand word
		ACT_CFG,    // write capacity_limit once idle
		ACT_SYNC,   // sender pause until all drain words are back
		ACT_HOLD    // kick off a long result stall
	} act_kind_e;

	typedef struct {
		act_kind_e kind;
		cand_t     word;
		cap_t      limit;
	} action_t;

	logic clk;
	logic arst_n;

	tkas_stream_if #(.T(cand_t))   cand_if ();
	tkas_stream_if #(.T(cap_t))    cfg_if ();
	tkas_stream_if #(.T(result_t)) res_if ();

	top_k_activity_selector #(
		.MAX_KEPT(MAX_KEPT)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cand   (cand_if),
		.cfg    (cfg_if),
		.result (res_if)
	);

	// ------------------------------------------------------------------
	// Shared bench state
	// ------------------------------------------------------------------
	action_t plan_q[$];          // pending stimulus, filled up front
	result_t drain_words_q[$];   // predicted result words, oldest first
	int      planned_items;
	int      mismatch_cnt;

	// written with NBAs only, so readers in other processes see the
	// value from before the edge
	int      outstanding;        // drain words still owed by the DUT
	logic    stim_done;
	logic    hold_req;           // toggles to start a long result stall

	// Predicted contents of the DUT
	logic [ID_W-1:0]    held_id  [MAX_KEPT];
	logic [SCORE_W-1:0] held_act [MAX_KEPT];
	int                 held_cnt;
	cap_t               cap_reg;

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * 8);
		$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	// capacity_limit 0 behaves as 1, anything above MAX_KEPT as MAX_KEPT
	function automatic int kept_limit();
		if (cap_reg == '0)
			return 1;
		if (int'(cap_reg) > MAX_KEPT)
			return MAX_KEPT;
		return int'(cap_reg);
	endfunction

	task automatic apply_limit(input cap_t value);
		cap_reg = value;
		// a lower limit drops the tail right away
		if (held_cnt > kept_limit())
			held_cnt = kept_limit();
	endtask

	task automatic rank_candidate(input logic [ID_W-1:0] id, input logic [SCORE_W-1:0] act);
		int lim;
		int pos;
		int j;
		lim = kept_limit();
		// duplicate id: list untouched, whatever the activity
		for (j = 0; j < held_cnt; j++) begin
			if (held_id[j] == id)
				return;
		end
		// goes ahead of the first strictly lower activity, ties keep order
		pos = held_cnt;
		for (j = 0; j < held_cnt; j++) begin
			if (held_act[j] < act) begin
				pos = j;
				break;
			end
		end
		// lands past the end of a full list: candidate itself falls off
		if (pos >= lim)
			return;
		for (j = (held_cnt < lim) ? held_cnt : lim - 1; j > pos; j--) begin
			held_id[j]  = held_id[j-1];
			held_act[j] = held_act[j-1];
		end
		held_id[pos]  = id;
		held_act[pos] = act;
		held_cnt      = (held_cnt < lim) ? held_cnt + 1 : lim;
	endtask

	task automatic emit_drain();
		result_t w;
		int k;
		if (held_cnt == 0) begin
			// empty list: one word, not valid, last set
			w = '{entry_valid: 1'b0, entry_id: '0, entry_activity: '0, last: 1'b1};
			drain_words_q.insert(drain_words_q.size(), w);
		end else begin
			for (k = 0; k < held_cnt; k++) begin
				w.entry_valid    = 1'b1;
				w.entry_id       = held_id[k];
				w.entry_activity = held_act[k];
				w.last           = (k == held_cnt - 1);
				drain_words_q.insert(drain_words_q.size(), w);
			end
		end
		held_cnt = 0;
	endtask

	task automatic check_word(input result_t got);
		result_t want;
		if (drain_words_q.size() == 0) begin
			$display("%0t: unexpected result word, expected none, got %h", $time, got);
			mismatch_cnt++;
			return;
		end
		want = drain_words_q.pop_front();
		if (got.entry_valid !== want.entry_valid) begin
			$display("%0t: entry_valid mismatch, expected %b, got %b",
				$time, want.entry_valid, got.entry_valid);
			mismatch_cnt++;
		end
		if (got.entry_id !== want.entry_id) begin
			$display("%0t: entry_id mismatch, expected %h, got %h",
				$time, want.entry_id, got.entry_id);
			mismatch_cnt++;
		end
		if (got.entry_activity !== want.entry_activity) begin
			$display("%0t: entry_activity mismatch, expected %h, got %h",
				$time, want.entry_activity, got.entry_activity);
			mismatch_cnt++;
		end
		if (got.last !== want.last) begin
			$display("%0t: last mismatch, expected %b, got %b", $time, want.last, got.last);
			mismatch_cnt++;
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: checks result words, predicts at cfg and cand handshakes
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt = 0;
			cap_reg  = CAP_RESET;
			outstanding <= 0;
		end else begin
			if (res_if.valid && res_if.ready)
				check_word(res_if.data);
			if (cfg_if.valid && cfg_if.ready)
				apply_limit(cfg_if.data);
			if (cand_if.valid && cand_if.ready) begin
				if (cand_if.data.operation == OP_DRAIN)
					emit_drain();
				else
					rank_candidate(cand_if.data.clause_id, cand_if.data.activity);
			end
			outstanding <= drain_words_q.size();
		end
	end

	// ------------------------------------------------------------------
	// Driver: works through plan_q, cand words in bursts with gaps
	// ------------------------------------------------------------------
	int quiet_cnt;    // cycles with nothing offered and nothing owed
	int gap_left;
	int burst_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_if.valid <= 1'b0;
			cand_if.data  <= '0;
			cfg_if.valid  <= 1'b0;
			cfg_if.data   <= '0;
			hold_req      <= 1'b0;
			stim_done     <= 1'b0;
			quiet_cnt  = 0;
			gap_left   = 0;
			burst_left = 0;
		end else begin
			if ((cand_if.valid && cand_if.ready) || (cfg_if.valid && cfg_if.ready))
				void'(plan_q.pop_front());

			if (outstanding == 0 && !cand_if.valid && !cfg_if.valid)
				quiet_cnt++;
			else
				quiet_cnt = 0;

			if (plan_q.size() == 0) begin
				cand_if.valid <= 1'b0;
				cfg_if.valid  <= 1'b0;
				stim_done     <= 1'b1;
			end else begin
				case (plan_q[0].kind)
					ACT_WORD: begin
						cfg_if.valid <= 1'b0;
						if (cand_if.valid && !cand_if.ready) begin
							// stalled: keep the word on the bus
						end else if (gap_left > 0) begin
							gap_left--;
							cand_if.valid <= 1'b0;
						end else begin
							cand_if.valid <= 1'b1;
							cand_if.data  <= plan_q[0].word;
							if (burst_left == 0) begin
								// new burst; mostly back to back, sometimes long gaps
								burst_left = $urandom_range(1, 40);
								gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
							end else begin
								burst_left--;
							end
						end
					end
					ACT_CFG: begin
						cand_if.valid <= 1'b0;
						if (cfg_if.valid && !cfg_if.ready) begin
							// wait for the write to go through
						end else if (quiet_cnt >= SETTLE) begin
							cfg_if.valid <= 1'b1;
							cfg_if.data  <= plan_q[0].limit;
						end else begin
							cfg_if.valid <= 1'b0;
						end
					end
					ACT_SYNC: begin
						cand_if.valid <= 1'b0;
						cfg_if.valid  <= 1'b0;
						if (quiet_cnt >= SETTLE)
							void'(plan_q.pop_front());
					end
					default: begin
						cand_if.valid <= 1'b0;
						cfg_if.valid  <= 1'b0;
						hold_req      <= ~hold_req;
						void'(plan_q.pop_front());
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stall modes, plus a long hold on request
	// ------------------------------------------------------------------
	logic hold_seen;
	int   hold_left;
	int   rx_mode;
	int   mode_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			hold_seen = 1'b0;
			hold_left = 0;
			rx_mode   = 0;
			mode_left = 0;
		end else begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (mode_left == 0) begin
				rx_mode   = $urandom_range(0, 3);
				mode_left = $urandom_range(10, 80);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				case (rx_mode)
					0, 1:    res_if.ready <= 1'b1;
					2:       res_if.ready <= 1'($urandom_range(0, 1));
					default: res_if.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus plan
	// ------------------------------------------------------------------
	task automatic add_word(input logic op, input logic [ID_W-1:0] id,
		input logic [SCORE_W-1:0] act);
		action_t a;
		a.kind  = ACT_WORD;
		a.word  = '{operation: op, clause_id: id, activity: act};
		a.limit = '0;
		plan_q.insert(plan_q.size(), a);
		planned_items++;
	endtask

	task automatic add_ctl(input act_kind_e kind, input cap_t value);
		action_t a;
		a.kind  = kind;
		a.word  = '0;
		a.limit = value;
		plan_q.insert(plan_q.size(), a);
	endtask

	initial begin
		int                 phase;
		int                 n;
		int                 k;
		int                 mid;
		int                 cut;
		int                 r;
		cap_t               lim;
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] act;
		logic [ID_W-1:0]    pool_ids[$];
		logic [SCORE_W-1:0] pool_acts[$];

		arst_n        = 1'b1;
		cand_if.valid = 1'b0;
		cand_if.data  = '0;
		cfg_if.valid  = 1'b0;
		cfg_if.data   = '0;
		res_if.ready  = 1'b0;
		mismatch_cnt  = 0;
		planned_items = 0;
		// reset edge lands once every clocked process waits on it
		arst_n <= 1'b0;

		// --- directed ---
		// drain of an empty list, then extremes, a tie and a duplicate
		add_word(OP_DRAIN, 32'h0, 32'h0);
		add_word(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
		add_word(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_word(OP_INSERT, 32'h0000_0005, 32'h0000_0000);   // tie, goes behind
		add_word(OP_INSERT, 32'h0000_0000, 32'h0000_0100);   // duplicate id
		add_word(OP_INSERT, 32'h0000_0007, 32'h8000_0000);
		add_word(OP_DRAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// limit 0 acts as 1: tie falls off, higher one replaces
		add_ctl(ACT_CFG, 5'd0);
		add_word(OP_INSERT, 32'h1, 32'd10);
		add_word(OP_INSERT, 32'h2, 32'd10);
		add_word(OP_INSERT, 32'h3, 32'd20);
		add_word(OP_DRAIN, 32'h0, 32'h0);
		// full list of two, tail pushed out
		add_ctl(ACT_CFG, 5'd2);
		add_word(OP_INSERT, 32'h10, 32'd1);
		add_word(OP_INSERT, 32'h11, 32'd2);
		add_word(OP_INSERT, 32'h12, 32'd3);
		add_word(OP_DRAIN, 32'h0, 32'h0);
		// limit lowered while entries are held
		add_ctl(ACT_CFG, 5'd3);
		add_word(OP_INSERT, 32'h20, 32'd30);
		add_word(OP_INSERT, 32'h21, 32'd20);
		add_word(OP_INSERT, 32'h22, 32'd10);
		add_ctl(ACT_CFG, 5'd1);
		add_word(OP_DRAIN, 32'h0, 32'h0);
		// limit above MAX_KEPT
		add_ctl(ACT_CFG, 5'd31);
		add_word(OP_INSERT, 32'hDEAD_BEEF, 32'h0000_0001);
		add_word(OP_DRAIN, 32'h0, 32'h0);

		// --- random phases: set limit, insert a batch, drain ---
		phase = 0;
		while (planned_items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			case (r)
				0:       lim = 5'd0;
				1:       lim = 5'd1;
				2:       lim = 5'd16;
				3:       lim = 5'd31;
				4, 5:    lim = cap_t'($urandom_range(0, 31));
				default: lim = cap_t'($urandom_range(2, 8));
			endcase
			// back pressure phase needs several held entries at its drain
			if (phase == 1)
				lim = 5'd16;
			add_ctl(ACT_CFG, lim);
			pool_ids.delete();
			pool_acts.delete();

			n   = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 26) : $urandom_range(1, 20);
			mid = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
			cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
			if (phase == 1) begin
				// back pressure: results held off while inserts keep coming
				n   = 20;
				mid = 4;
				cut = -1;
				add_ctl(ACT_HOLD, '0);
			end

			for (k = 0; k < n; k++) begin
				if (k == mid)
					add_word(OP_DRAIN, $urandom, $urandom);
				if (k == cut)
					add_ctl(ACT_CFG, cap_t'($urandom_range(0, int'(lim))));
				r = $urandom_range(0, 9);
				if (r < 2 && pool_ids.size() > 0 && phase != 1)
					id = pool_ids[$urandom_range(0, pool_ids.size() - 1)];
				else if (r == 2 && phase != 1)
					id = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
				else
					id = $urandom;
				r = $urandom_range(0, 9);
				if (r < 2)
					act = $urandom_range(0, 3);
				else if (r == 2)
					act = 32'hFFFF_FFFF - $urandom_range(0, 1);
				else if (r == 3 && pool_acts.size() > 0)
					act = pool_acts[$urandom_range(0, pool_acts.size() - 1)];
				else
					act = $urandom;
				pool_ids.insert(pool_ids.size(), id);
				pool_acts.insert(pool_acts.size(), act);
				add_word(OP_INSERT, id, act);
			end

			add_word(OP_DRAIN, $urandom, $urandom);
			if ($urandom_range(0, 4) == 0)
				add_word(OP_DRAIN, $urandom, $urandom);   // hits the empty list
			if (phase == 1 || $urandom_range(0, 2) == 0)
				add_ctl(ACT_SYNC, '0);
			phase++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (!(stim_done && outstanding == 0))
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0 && drain_words_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
